### hw/rtl/fifo_with_delete_by_value_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delete-by-value FIFO
// Shared implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_DELETE_BY_VALUE_TOP_DEFINES_SVH
`define FIFO_WITH_DELETE_BY_VALUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FDV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FDV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/fdv_pkg.sv
// ----------------------------------------------------------------------------
// fdv_pkg
// Types and constants of the FIFO with delete by value.
// ----------------------------------------------------------------------------
`default_nettype none

package fdv_pkg;

   localparam int DEPTH_DEFAULT        = 16;
   localparam int HANDLE_WIDTH_DEFAULT = 32;
   localparam int CMD_WIDTH            = 2;
   localparam int STATUS_WIDTH         = 3;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_DELETE  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_ZERO_KEY  = 3'd4
   } status_type;

   // Operation broadcast to every cell of the row.
   typedef enum logic [1:0] {
      OP_HOLD    = 2'd0,
      OP_APPEND  = 2'd1,
      OP_POP     = 2'd2,
      OP_REMOVE  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### hw/rtl/fdv_cell.sv
// ----------------------------------------------------------------------------
// fdv_cell
// One slot of the queue: holds an entry, compares it with the key and takes
// its neighbor's entry when the row compacts.
// ----------------------------------------------------------------------------
`default_nettype none

module fdv_cell #(
   parameter int HANDLE_WIDTH = fdv_pkg::HANDLE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH  = 5,
   parameter int INDEX        = 0
) (
   input  wire logic                      clock,
   input  wire fdv_pkg::cell_ctrl_type    ctrl,
   input  wire logic [COUNT_WIDTH-1:0]    count,
   input  wire logic [HANDLE_WIDTH-1:0]   handle,
   input  wire logic [HANDLE_WIDTH-1:0]   next_data,
   input  wire logic                      hit_in,
   output logic                           hit_out,
   output logic [HANDLE_WIDTH-1:0]        data
);
   import fdv_pkg::*;

   logic [HANDLE_WIDTH-1:0] data_ff;
   logic [HANDLE_WIDTH-1:0] data_in;
   logic                    occupied;
   logic                    my_hit;

   assign occupied = COUNT_WIDTH'(INDEX) < count;
   assign my_hit   = occupied && (data_ff == handle);
   // Once a match is seen at or ahead of this cell, this cell closes the gap.
   assign hit_out  = hit_in || my_hit;
   assign data     = data_ff;

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         OP_APPEND: begin
            if (count == COUNT_WIDTH'(INDEX)) begin
               data_in = handle;
            end
         end
         OP_POP:    data_in = next_data;
         OP_REMOVE: begin
            if (hit_out) begin
               data_in = next_data;
            end
         end
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

### hw/rtl/fifo_with_delete_by_value_top.sv
// A result strobes in the cycle after its command is accepted.
// Throughput: one command per cycle; busy is never raised by traffic.
// The row of cells matches all entries against the key in the same cycle
// and shifts to compact, so the ripple of the match chain sets the clock.
// Reset: synchronous; clears the length and holds busy high for its duration.
// ----------------------------------------------------------------------------
// fifo_with_delete_by_value_top
// Ordered queue of handles with enqueue, dequeue and delete of the first match.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_delete_by_value_top #(
   parameter int DEPTH        = fdv_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_WIDTH = fdv_pkg::HANDLE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH  = $clog2(DEPTH + 1)
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [fdv_pkg::CMD_WIDTH-1:0]        req_cmd,
   input  wire logic [HANDLE_WIDTH-1:0]              req_handle,
   output logic                                      rsp_valid,
   output logic [fdv_pkg::STATUS_WIDTH-1:0]          rsp_status,
   output logic [HANDLE_WIDTH-1:0]                   rsp_handle_out,
   output logic [COUNT_WIDTH-1:0]                    rsp_length
);
   import fdv_pkg::*;

   logic                    busy_ff;
   logic [COUNT_WIDTH-1:0]  count_ff;
   logic [COUNT_WIDTH-1:0]  count_in;
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   status_type              rsp_status_in;
   logic [HANDLE_WIDTH-1:0] rsp_handle_ff;
   logic [HANDLE_WIDTH-1:0] rsp_handle_in;
   logic                    accept;
   cell_ctrl_type           ctrl;
   logic [DEPTH:0]          hit;
   logic [HANDLE_WIDTH-1:0] data [DEPTH];

   assign accept = start && !busy_ff;
   assign hit[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [HANDLE_WIDTH-1:0] next_data;
      if (i == DEPTH - 1) begin : g_tail
         assign next_data = '0;
      end else begin : g_mid
         assign next_data = data[i+1];
      end
      fdv_cell #(
         .HANDLE_WIDTH (HANDLE_WIDTH),
         .COUNT_WIDTH  (COUNT_WIDTH),
         .INDEX        (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count_ff),
         .handle    (req_handle),
         .next_data (next_data),
         .hit_in    (hit[i]),
         .hit_out   (hit[i+1]),
         .data      (data[i])
      );
   end

   always_comb begin
      ctrl.op       = OP_HOLD;
      count_in      = count_ff;
      rsp_status_in = ST_OK;
      rsp_handle_in = '0;
      if (accept) begin
         unique case (req_cmd)
            CMD_ENQUEUE: begin
               if (count_ff == COUNT_WIDTH'(DEPTH)) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  ctrl.op  = OP_APPEND;
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
            end
            CMD_DEQUEUE: begin
               if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  ctrl.op       = OP_POP;
                  rsp_handle_in = data[0];
                  count_in      = count_ff - COUNT_WIDTH'(1);
               end
            end
            CMD_DELETE: begin
               priority if (req_handle == '0) begin
                  rsp_status_in = ST_ZERO_KEY;
               end else if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else if (hit[DEPTH]) begin
                  ctrl.op  = OP_REMOVE;
                  count_in = count_ff - COUNT_WIDTH'(1);
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
               end
            end
            default: begin
               rsp_status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_length     = count_ff;

endmodule

`default_nettype wire

### hw/rtl/fdv_checker.sv
// ----------------------------------------------------------------------------
// fdv_checker
// Port-level checks of the delete-by-value FIFO, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fifo_with_delete_by_value_top_defines.svh"

module fdv_checker #(
   parameter int DEPTH        = fdv_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_WIDTH = fdv_pkg::HANDLE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH  = $clog2(DEPTH + 1)
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic                             rsp_valid,
   input wire logic [fdv_pkg::STATUS_WIDTH-1:0] rsp_status,
   input wire logic [HANDLE_WIDTH-1:0]          rsp_handle_out,
   input wire logic [COUNT_WIDTH-1:0]           rsp_length
);
   import fdv_pkg::*;

   // Every accepted command produces exactly one result in the next cycle.
   `FDV_ASSERT_NEXT(a_result_follows, clock, reset, start && !busy, rsp_valid, "missing result")
   `FDV_ASSERT_SAME(a_no_spurious, clock, reset, rsp_valid, $past(start && !busy), "extra result")
   // Only a successful dequeue returns a handle.
   `FDV_ASSERT_SAME(a_handle_ok, clock, reset, rsp_valid && (rsp_handle_out != '0), rsp_status == ST_OK, "handle on failure")
   `FDV_ASSERT_SAME(a_length_bound, clock, reset, rsp_valid, rsp_length <= COUNT_WIDTH'(DEPTH), "length over depth")

endmodule

bind fifo_with_delete_by_value_top fdv_checker #(
   .DEPTH        (DEPTH),
   .HANDLE_WIDTH (HANDLE_WIDTH),
   .COUNT_WIDTH  (COUNT_WIDTH)
) u_fdv_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_handle_out (rsp_handle_out),
   .rsp_length     (rsp_length)
);

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives enqueue, dequeue and delete-by-value commands with random gaps into
// the handle queue and checks every result against a queue kept on the side.
// ----------------------------------------------------------------------------
module tb;
   import fdv_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam int HW = HANDLE_WIDTH_DEFAULT;
   localparam int LW = $clog2(DEPTH + 1);
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_OPS = 1300;
   localparam int SETTLE_CYCLES = 4;

   typedef struct {
      logic [CMD_WIDTH-1:0] cmd;
      logic [HW-1:0]        handle;
      int unsigned          gap;
      bit                   drain;
   } command_type;

   typedef struct {
      logic [STATUS_WIDTH-1:0] status;
      logic [HW-1:0]           handle;
      logic [LW-1:0]           length;
   } outcome_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [CMD_WIDTH-1:0]    req_cmd = '0;
   logic [HW-1:0]           req_handle = '0;
   logic                    rsp_valid;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic [HW-1:0]           rsp_handle_out;
   logic [LW-1:0]           rsp_length;

   command_type pending_cmds[$];
   outcome_type expected_outcomes[$];
   // Predicted queue contents, head first.
   logic [HW-1:0] held_handles[$];
   logic [HW-1:0] key_pool[8];

   command_type current;
   bit          armed = 1'b0;
   bit          took = 1'b0;
   int unsigned wait_cycles = 0;
   int unsigned issued = 0;
   int unsigned accepted = 0;
   int unsigned mismatches = 0;

   fifo_with_delete_by_value_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_handle     (req_handle),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_handle_out (rsp_handle_out),
      .rsp_length     (rsp_length)
   );

   always #5 clock = ~clock;

   function automatic outcome_type apply_command(logic [CMD_WIDTH-1:0] cmd,
                                                 logic [HW-1:0] handle);
      outcome_type res;
      int          pos;
      res.status = ST_OK;
      res.handle = '0;
      pos = -1;
      case (cmd)
         CMD_ENQUEUE: begin
            if (held_handles.size() >= DEPTH) res.status = ST_FULL;
            else held_handles.push_back(handle);
         end
         CMD_DEQUEUE: begin
            if (held_handles.size() == 0) res.status = ST_EMPTY;
            else res.handle = held_handles.pop_front();
         end
         CMD_DELETE: begin
            // A zero key is rejected before the queue is even looked at.
            if (handle == '0) begin
               res.status = ST_ZERO_KEY;
            end else if (held_handles.size() == 0) begin
               res.status = ST_EMPTY;
            end else begin
               foreach (held_handles[i])
                  if (pos < 0 && held_handles[i] == handle) pos = i;
               if (pos < 0) res.status = ST_NOT_FOUND;
               else held_handles.delete(pos);
            end
         end
         default: ;
      endcase
      res.length = LW'(held_handles.size());
      return res;
   endfunction

   task automatic queue_command(logic [CMD_WIDTH-1:0] cmd, logic [HW-1:0] handle,
                                int unsigned gap, bit drain);
      command_type c;
      c.cmd = cmd;
      c.handle = handle;
      c.gap = gap;
      c.drain = drain;
      pending_cmds.push_back(c);
      issued++;
   endtask

   // Driver: holds a command until it is taken, then idles for the gap of the
   // next one. A draining command waits until every result has come back.
   always @(negedge clock) begin
      if (!reset && !(start && !took)) begin
         if (!armed && pending_cmds.size() > 0) begin
            current = pending_cmds.pop_front();
            wait_cycles = current.gap;
            armed = 1'b1;
         end
         if (armed && wait_cycles == 0 &&
             !(current.drain && expected_outcomes.size() > 0)) begin
            start <= 1'b1;
            req_cmd <= current.cmd;
            req_handle <= current.handle;
            armed = 1'b0;
         end else begin
            if (armed && wait_cycles > 0) wait_cycles--;
            start <= 1'b0;
            req_cmd <= CMD_WIDTH'($urandom);
            req_handle <= HW'($urandom);
         end
      end
   end

   // Monitor: checks each strobed result against the oldest prediction, then
   // predicts the command taken at this edge.
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         took <= 1'b0;
      end else begin
         took <= start && !busy;
         if (rsp_valid === 1'b1) begin
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with nothing expected: status %0d handle %h len %0d",
                           $realtime, rsp_status, rsp_handle_out, rsp_length);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_status !== want.status || rsp_handle_out !== want.handle ||
                   rsp_length !== want.length) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: expected status %0d handle %h len %0d, got %0d %h %0d",
                              $realtime, want.status, want.handle, want.length,
                              rsp_status, rsp_handle_out, rsp_length);
               end
            end
         end
         if (start && !busy) begin
            expected_outcomes.push_back(apply_command(req_cmd, req_handle));
            accepted++;
         end
      end
   end

   initial begin
      int unsigned          enq_pct;
      bit                   gaps_on;
      int unsigned          roll;
      logic [CMD_WIDTH-1:0] cmd;
      logic [HW-1:0]        handle;

      // Directed part: empty cases, fill to the top with duplicates, then
      // hit the tail, the first of several matches, a miss and a zero key.
      queue_command(CMD_DEQUEUE, 32'h1234_5678, 0, 1'b0);
      queue_command(CMD_DELETE, 32'h0000_0005, 1, 1'b0);
      queue_command(CMD_DELETE, '0, 0, 1'b0);
      queue_command(CMD_UNUSED, 32'hFFFF_FFFF, 0, 1'b0);
      queue_command(CMD_ENQUEUE, '0, 0, 1'b0);
      queue_command(CMD_ENQUEUE, 32'hFFFF_FFFF, 2, 1'b0);
      for (int k = 0; k < DEPTH - 3; k++)
         queue_command(CMD_ENQUEUE, HW'(32'h100 + k % 5), $urandom_range(0, 3), 1'b0);
      queue_command(CMD_ENQUEUE, 32'hA5A5_0001, 0, 1'b0);
      queue_command(CMD_ENQUEUE, 32'h0BAD_0BAD, 0, 1'b0);
      queue_command(CMD_DELETE, 32'hA5A5_0001, 0, 1'b0);
      queue_command(CMD_DELETE, 32'h0000_0102, 0, 1'b0);
      queue_command(CMD_DELETE, '0, 1, 1'b0);
      queue_command(CMD_DELETE, 32'h5A5A_5A5A, 0, 1'b0);
      queue_command(CMD_DELETE, 32'hFFFF_FFFF, 0, 1'b0);
      queue_command(CMD_DEQUEUE, 32'hFFFF_FFFF, 0, 1'b1);

      // Keys mostly come from a small pool so that deletes find matches.
      key_pool[0] = 32'hFFFF_FFFF;
      for (int k = 1; k < 8; k++) key_pool[k] = HW'($urandom);

      enq_pct = 50;
      gaps_on = 1'b1;
      for (int i = 0; i < RANDOM_OPS; i++) begin
         if (i % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: enq_pct = 20;
               1: enq_pct = 50;
               default: enq_pct = 85;
            endcase
            gaps_on = $urandom_range(0, 3) != 0;
         end
         roll = $urandom_range(0, 99);
         if (roll < 2) cmd = CMD_UNUSED;
         else if (roll < enq_pct) cmd = CMD_ENQUEUE;
         else if (roll < enq_pct + (100 - enq_pct) / 2) cmd = CMD_DEQUEUE;
         else cmd = CMD_DELETE;
         case ($urandom_range(0, 9))
            0: handle = '0;
            1: handle = HW'($urandom);
            default: handle = key_pool[$urandom_range(0, 7)];
         endcase
         queue_command(cmd, handle, gaps_on ? $urandom_range(0, 15) : 0, i % 250 == 249);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted < issued || expected_outcomes.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### fifo_with_delete_by_value_top.f
+incdir+hw/rtl
hw/rtl/fdv_pkg.sv
hw/rtl/fdv_cell.sv
hw/rtl/fifo_with_delete_by_value_top.sv
hw/rtl/fdv_checker.sv
verif/tb.sv
